>>> rtl/vertex_normal_accumulator_core_defines.svh
// assertion macros for the vertex normal accumulator
`ifndef VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define VNA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define VNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define VNA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VNA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/vna_pkg.sv
// shared types and constants of the vertex normal accumulator
package vna_pkg;
	localparam int SLOTS_DEFAULT = 1024;
	localparam int INDEX_W = 10;
	localparam int COORD_W = 32;
	localparam int SUM_W = 64;
	localparam int COUNT_W = 16;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_TRI = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [INDEX_W-1:0] vertex_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [INDEX_W-1:0] corner_a;
		logic [INDEX_W-1:0] corner_b;
		logic [INDEX_W-1:0] corner_c;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] normal_x;
		logic signed [COORD_W-1:0] normal_y;
		logic signed [COORD_W-1:0] normal_z;
		logic [COUNT_W-1:0] hit_count;
		logic no_hits;
	} rsp_t;
endpackage

>>> rtl/vna_stream_if.sv
// valid/ready channel carrying one payload
interface vna_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/vertex_normal_accumulator_core.sv
// vertex normal accumulator: position table, normal sums, averaging divider
// Requests are handled one at a time. A position write is done when the request
// is taken, a clear sweeps the sum memory one entry a cycle (also right after
// reset, when no request is taken), a triangle runs three position reads, a
// multiply and a subtract stage, then a read and a write of the sum memory per
// corner, and a read runs a radix-2 divider that works 64 quotient bits on all
// three axes at once (the divider is skipped when the count is zero). A finished
// read result is held in an output register, so the next request is taken while
// it waits.
`include "vertex_normal_accumulator_core_defines.svh"
module vertex_normal_accumulator_core #(
	parameter int VERTEX_SLOTS = vna_pkg::SLOTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	vna_stream_if.sink req,
	vna_stream_if.source rsp
);
	localparam int IW = $clog2(VERTEX_SLOTS);
	localparam logic [19:0] RECIP = 20'((1 << 20) / VERTEX_SLOTS);
	localparam logic [16:0] SLOTS_V = 17'(VERTEX_SLOTS);
	localparam logic [IW-1:0] LAST_SLOT = IW'(VERTEX_SLOTS - 1);

	localparam logic [3:0] ST_CLR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RD = 4'd2;
	localparam logic [3:0] ST_LOAD = 4'd3;
	localparam logic [3:0] ST_DIV = 4'd4;
	localparam logic [3:0] ST_OUT = 4'd5;
	localparam logic [3:0] ST_PRD = 4'd6;
	localparam logic [3:0] ST_MUL = 4'd7;
	localparam logic [3:0] ST_SUB = 4'd8;
	localparam logic [3:0] ST_ARD = 4'd9;
	localparam logic [3:0] ST_AWR = 4'd10;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	typedef struct packed {
		logic signed [63:0] sx;
		logic signed [63:0] sy;
		logic signed [63:0] sz;
		logic [15:0] cnt;
	} acc_entry_t;

	function automatic logic [IW-1:0] slot_of(input logic [9:0] idx);
		logic [29:0] prod;
		logic [26:0] qs;
		logic [16:0] r;
		prod = 30'(idx) * 30'(RECIP);
		qs = 27'(prod[29:20]) * 27'(SLOTS_V);
		r = 17'(idx) - qs[16:0];
		if (r >= SLOTS_V) begin
			r = r - SLOTS_V;
		end
		return r[IW-1:0];
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			s = a[63] ? S64_MIN : S64_MAX;
		end
		return s;
	endfunction

	function automatic logic [63:0] mag_of(input logic signed [63:0] s);
		return s[63] ? (~s + 64'd1) : s;
	endfunction

	function automatic logic [31:0] sat_out(input logic [63:0] q, input logic neg);
		logic [31:0] r;
		if (neg) begin
			r = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(~q + 64'd1);
		end else begin
			r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end
		return r;
	endfunction

	logic [3:0] state_q;
	logic [5:0] step_q;
	logic [IW-1:0] clr_ptr_q;
	logic out_valid_q;
	vna_pkg::req_t item_q;
	vna_pkg::rsp_t out_q;

	logic [95:0] pos_mem [VERTEX_SLOTS];
	acc_entry_t acc_mem [VERTEX_SLOTS];
	logic [95:0] pos_rd_q;
	acc_entry_t acc_rd_q;
	logic [95:0] pt_q [3];
	logic signed [65:0] prod_s1 [6];
	logic signed [63:0] face_q [3];
	logic [63:0] quo_q [3];
	logic [15:0] rem_q [3];
	logic neg_q [3];
	logic [15:0] div_d_q;

	logic req_fire;
	logic out_free;
	logic clr_last;
	logic [1:0] csel;
	logic [IW-1:0] corner_slot [3];
	logic [IW-1:0] pos_raddr;
	logic [IW-1:0] acc_raddr;
	logic acc_we;
	logic [IW-1:0] acc_waddr;
	acc_entry_t acc_wdata;
	logic signed [32:0] ex, ey, ez, fx, fy, fz;
	logic signed [66:0] dif [3];
	logic [63:0] quo_nx [3];
	logic [15:0] rem_nx [3];
	logic [16:0] part [3];
	logic [16:0] part_sub [3];

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;
	assign clr_last = (state_q == ST_CLR) && (clr_ptr_q == LAST_SLOT);

	assign corner_slot[0] = slot_of(item_q.corner_a);
	assign corner_slot[1] = slot_of(item_q.corner_b);
	assign corner_slot[2] = slot_of(item_q.corner_c);
	assign csel = (step_q[1:0] == 2'd3) ? 2'd2 : step_q[1:0];
	assign pos_raddr = corner_slot[csel];
	assign acc_raddr = (state_q == ST_RD) ? slot_of(item_q.vertex_index) : corner_slot[csel];

	always_comb begin
		acc_we = (state_q == ST_CLR) || (state_q == ST_AWR);
		acc_waddr = (state_q == ST_CLR) ? clr_ptr_q : corner_slot[csel];
		acc_wdata.sx = sat_add(acc_rd_q.sx, face_q[0]);
		acc_wdata.sy = sat_add(acc_rd_q.sy, face_q[1]);
		acc_wdata.sz = sat_add(acc_rd_q.sz, face_q[2]);
		acc_wdata.cnt = (acc_rd_q.cnt == 16'hFFFF) ? acc_rd_q.cnt : acc_rd_q.cnt + 16'd1;
		if (state_q == ST_CLR) begin
			acc_wdata = '0;
		end
	end

	always_comb begin
		ex = $signed({pt_q[1][95], pt_q[1][95:64]}) - $signed({pt_q[0][95], pt_q[0][95:64]});
		ey = $signed({pt_q[1][63], pt_q[1][63:32]}) - $signed({pt_q[0][63], pt_q[0][63:32]});
		ez = $signed({pt_q[1][31], pt_q[1][31:0]}) - $signed({pt_q[0][31], pt_q[0][31:0]});
		fx = $signed({pt_q[2][95], pt_q[2][95:64]}) - $signed({pt_q[1][95], pt_q[1][95:64]});
		fy = $signed({pt_q[2][63], pt_q[2][63:32]}) - $signed({pt_q[1][63], pt_q[1][63:32]});
		fz = $signed({pt_q[2][31], pt_q[2][31:0]}) - $signed({pt_q[1][31], pt_q[1][31:0]});
		for (int i = 0; i < 3; i++) begin
			dif[i] = 67'(prod_s1[2*i]) - 67'(prod_s1[2*i+1]);
			part[i] = {rem_q[i], quo_q[i][63]};
			part_sub[i] = part[i] - {1'b0, div_d_q};
			if (part[i] >= {1'b0, div_d_q}) begin
				rem_nx[i] = part_sub[i][15:0];
				quo_nx[i] = {quo_q[i][62:0], 1'b1};
			end else begin
				rem_nx[i] = part[i][15:0];
				quo_nx[i] = {quo_q[i][62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && req.payload.action == vna_pkg::ACT_WRITE) begin
			pos_mem[slot_of(req.payload.vertex_index)] <=
				{req.payload.coord_x, req.payload.coord_y, req.payload.coord_z};
		end
		pos_rd_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[acc_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			step_q <= '0;
			clr_ptr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_ptr_q <= clr_ptr_q + IW'(1);
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					step_q <= '0;
					clr_ptr_q <= '0;
					if (req_fire) begin
						case (req.payload.action)
							vna_pkg::ACT_TRI: state_q <= ST_PRD;
							vna_pkg::ACT_READ: state_q <= ST_RD;
							vna_pkg::ACT_CLEAR: state_q <= ST_CLR;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RD: state_q <= ST_LOAD;
				ST_LOAD: begin
					step_q <= '0;
					state_q <= (acc_rd_q.cnt == 16'd0) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PRD: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd3) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SUB;
				ST_SUB: begin
					step_q <= '0;
					state_q <= ST_ARD;
				end
				ST_ARD: state_q <= ST_AWR;
				ST_AWR: begin
					step_q <= step_q + 6'd1;
					state_q <= (step_q == 6'd2) ? ST_IDLE : ST_ARD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= req.payload;
		end
		if (state_q == ST_PRD && step_q != 6'd0) begin
			pt_q[step_q[1:0] - 2'd1] <= pos_rd_q;
		end
		if (state_q == ST_MUL) begin
			prod_s1[0] <= ey * fz;
			prod_s1[1] <= ez * fy;
			prod_s1[2] <= ez * fx;
			prod_s1[3] <= ex * fz;
			prod_s1[4] <= ex * fy;
			prod_s1[5] <= ey * fx;
		end
		if (state_q == ST_SUB) begin
			for (int i = 0; i < 3; i++) begin
				face_q[i] <= 64'(dif[i] >>> 16);
			end
		end
		if (state_q == ST_LOAD) begin
			div_d_q <= acc_rd_q.cnt;
			quo_q[0] <= mag_of(acc_rd_q.sx);
			quo_q[1] <= mag_of(acc_rd_q.sy);
			quo_q[2] <= mag_of(acc_rd_q.sz);
			neg_q[0] <= acc_rd_q.sx[63];
			neg_q[1] <= acc_rd_q.sy[63];
			neg_q[2] <= acc_rd_q.sz[63];
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			for (int i = 0; i < 3; i++) begin
				quo_q[i] <= quo_nx[i];
				rem_q[i] <= rem_nx[i];
			end
		end
		if (state_q == ST_OUT && out_free) begin
			out_q.hit_count <= div_d_q;
			out_q.no_hits <= (div_d_q == 16'd0);
			out_q.normal_x <= (div_d_q == 16'd0) ? '0 : sat_out(quo_q[0], neg_q[0]);
			out_q.normal_y <= (div_d_q == 16'd0) ? '0 : sat_out(quo_q[1], neg_q[1]);
			out_q.normal_z <= (div_d_q == 16'd0) ? '0 : sat_out(quo_q[2], neg_q[2]);
		end
	end

	`VNA_ASSERT_SAME(a_div_nonzero, clk, arst_n, state_q == ST_DIV, div_d_q != 16'd0)
	`VNA_ASSERT_NEXT(a_clr_done, clk, arst_n, clr_last, state_q == ST_IDLE)
	`VNA_ASSERT_SAME(a_corner_step, clk, arst_n, state_q == ST_ARD || state_q == ST_AWR, step_q < 6'd3)
endmodule
